/* rtl/skit_pkg.sv */
`timescale 1ns / 1ps

package skit_pkg;

    localparam int KEY_W    = 32;
    localparam int ENERGY_W = 32;
    localparam int SLOT_W   = 11;
    localparam int IN_W     = KEY_W + ENERGY_W;
    localparam int OUT_W    = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH_ADDR,
        ST_SEARCH_CMP,
        ST_DECIDE,
        ST_SHIFT,
        ST_SHIFT_LAST,
        ST_INSERT,
        ST_DONE
    } skit_state_t;

endpackage

/* rtl/skit_store.sv */
`timescale 1ns / 1ps

module skit_store
    import skit_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [$clog2(MAX_ENTRIES)-1:0]      wr_addr,
    input  logic [KEY_W-1:0]                    wr_key,
    input  logic [ENERGY_W-1:0]                 wr_energy,
    input  logic [$clog2(MAX_ENTRIES)-1:0]      rd_addr,
    output logic [KEY_W-1:0]                    rd_key,
    output logic [ENERGY_W-1:0]                 rd_energy
);

    logic [KEY_W-1:0]    key_mem    [MAX_ENTRIES];
    logic [ENERGY_W-1:0] energy_mem [MAX_ENTRIES];
    logic [KEY_W-1:0]    rd_key_reg;
    logic [ENERGY_W-1:0] rd_energy_reg;

    // one write port and one registered read port, shared by both arrays
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]    <= wr_key;
            energy_mem[wr_addr] <= wr_energy;
        end
        rd_key_reg    <= key_mem[rd_addr];
        rd_energy_reg <= energy_mem[rd_addr];
    end

    assign rd_key    = rd_key_reg;
    assign rd_energy = rd_energy_reg;

endmodule

/* rtl/sorted_key_insert_table_unit.sv */
`timescale 1ns / 1ps

// channel   | dir | fields (lowest bit up)                               | handshake
// s_axis    | in  | tdata: state_key[31:0], state_energy[63:32]          | tvalid/tready
// m_axis    | out | tdata: slot_position[10:0], already_present[11],     | tvalid/tready
//           |     |        table_full[12], zero[15:13]                   |
//
// per item: each binary-search probe is a registered table read, then one shared
// key compare, about log2(entry_count+1) probes; then the upward shift (one entry
// moved per cycle over the single write port), the write of the new entry and the
// control states. The worst case is set by the shift.
// reset clears the entry count and the sequencer; the table contents need no clear
// since only entries below the count are read. s_axis_tready is high only while
// idle; a finished result waits in the output register, holding m_axis_tdata stable.

module sorted_key_insert_table_unit
    import skit_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024,
    parameter int MODE_COUNT  = 8,
    parameter int QUANTA_BITS = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // state_key, state_energy
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // slot_position, already_present, table_full
);

    localparam int IDX_W     = $clog2(MAX_ENTRIES);
    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int USED_BITS = MODE_COUNT * QUANTA_BITS;
    localparam int LOW_BITS  = (USED_BITS >= KEY_W) ? 0 : (KEY_W - USED_BITS);
    localparam logic [KEY_W-1:0] KEY_MASK = ~((KEY_W'(1) << LOW_BITS) - KEY_W'(1));
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ENTRIES);
    localparam int POS_EXT_W = CNT_W + SLOT_W;

    skit_state_t state_reg, state_next;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [CNT_W-1:0]    mid_reg, mid_next;
    logic                hit_reg, hit_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [ENERGY_W-1:0] energy_reg, energy_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic [IDX_W-1:0]    wptr_reg, wptr_next;
    logic                pend_reg, pend_next;
    logic                res_present_reg, res_present_next;
    logic                res_full_reg, res_full_next;

    logic                out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic                out_present_reg, out_present_next;
    logic                out_full_reg, out_full_next;

    logic [CNT_W-1:0]    mid_calc;
    logic                key_less;
    logic                key_equal;
    logic                out_free;
    logic [POS_EXT_W-1:0] pos_ext;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [KEY_W-1:0]     wr_key;
    logic [ENERGY_W-1:0]  wr_energy;
    logic [IDX_W-1:0]     rd_addr;
    logic [KEY_W-1:0]     rd_key;
    logic [ENERGY_W-1:0]  rd_energy;

    skit_store #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_key    (wr_key),
        .wr_energy (wr_energy),
        .rd_addr   (rd_addr),
        .rd_key    (rd_key),
        .rd_energy (rd_energy)
    );

    // shared compare unit and probe midpoint
    assign key_less  = rd_key < key_reg;
    assign key_equal = rd_key == key_reg;
    assign mid_calc  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign pos_ext   = POS_EXT_W'(hi_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = (count_reg != '0) ? ST_SEARCH_ADDR : ST_DECIDE;
                end
            end
            ST_SEARCH_ADDR:
            begin
                state_next = ST_SEARCH_CMP;
            end
            ST_SEARCH_CMP:
            begin
                state_next = (lo_next < hi_next) ? ST_SEARCH_ADDR : ST_DECIDE;
            end
            ST_DECIDE:
            begin
                priority if (hit_reg || count_reg == FULL_COUNT)
                begin
                    state_next = ST_DONE;
                end
                else if (hi_reg < count_reg)
                begin
                    state_next = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_SHIFT:
            begin
                if (CNT_W'(ptr_reg) == hi_reg)
                begin
                    state_next = ST_SHIFT_LAST;
                end
            end
            ST_SHIFT_LAST:
            begin
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs: table port controls and input ready
    always_comb
    begin
        s_axis_tready = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = wptr_reg;
        wr_key        = rd_key;
        wr_energy     = rd_energy;
        rd_addr       = ptr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_SEARCH_ADDR:
            begin
                rd_addr = mid_calc[IDX_W-1:0];
            end
            ST_SHIFT:
            begin
                // read entry ptr while the entry read last cycle lands one slot up
                wr_en = pend_reg;
            end
            ST_SHIFT_LAST:
            begin
                wr_en = 1'b1;
            end
            ST_INSERT:
            begin
                wr_en     = 1'b1;
                wr_addr   = hi_reg[IDX_W-1:0];
                wr_key    = key_reg;
                wr_energy = energy_reg;
            end
            default:
            begin
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        count_next       = count_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        mid_next         = mid_reg;
        hit_next         = hit_reg;
        key_next         = key_reg;
        energy_next      = energy_reg;
        ptr_next         = ptr_reg;
        wptr_next        = wptr_reg;
        pend_next        = pend_reg;
        res_present_next = res_present_reg;
        res_full_next    = res_full_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_slot_next    = out_slot_reg;
        out_present_next = out_present_reg;
        out_full_next    = out_full_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                key_next    = s_axis_tdata[KEY_W-1:0] & KEY_MASK;
                energy_next = s_axis_tdata[IN_W-1:KEY_W];
                lo_next     = '0;
                hi_next     = count_reg;
                hit_next    = 1'b0;
            end
            ST_SEARCH_ADDR:
            begin
                mid_next = mid_calc;
            end
            ST_SEARCH_CMP:
            begin
                if (key_less)
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    // hi always ends on the last probe that moved it
                    hi_next  = mid_reg;
                    hit_next = key_equal;
                end
            end
            ST_DECIDE:
            begin
                res_present_next = hit_reg;
                res_full_next    = !hit_reg && count_reg == FULL_COUNT;
                ptr_next         = IDX_W'(count_reg - CNT_W'(1));
                pend_next        = 1'b0;
            end
            ST_SHIFT:
            begin
                pend_next = 1'b1;
                wptr_next = ptr_reg + IDX_W'(1);
                if (CNT_W'(ptr_reg) != hi_reg)
                begin
                    ptr_next = ptr_reg - IDX_W'(1);
                end
            end
            ST_INSERT:
            begin
                count_next = count_reg + CNT_W'(1);
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_slot_next    = pos_ext[SLOT_W-1:0];
                    out_present_next = res_present_reg;
                    out_full_next    = res_full_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        mid_reg         <= mid_next;
        hit_reg         <= hit_next;
        key_reg         <= key_next;
        energy_reg      <= energy_next;
        ptr_reg         <= ptr_next;
        wptr_reg        <= wptr_next;
        pend_reg        <= pend_next;
        res_present_reg <= res_present_next;
        res_full_reg    <= res_full_next;
        out_slot_reg    <= out_slot_next;
        out_present_reg <= out_present_next;
        out_full_reg    <= out_full_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W - SLOT_W - 2){1'b0}}, out_full_reg, out_present_reg,
                            out_slot_reg};

    // entry count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond table size");

    // a result never claims both a hit and a drop
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[SLOT_W] && m_axis_tdata[SLOT_W+1]))
        else $error("present and full both set");

    // each insert grows the table by exactly one
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INSERT |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not advance entry count");

    // the table is written only while shifting or inserting
    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_SHIFT || state_reg == ST_SHIFT_LAST ||
                   state_reg == ST_INSERT))
        else $error("table write outside shift or insert");

endmodule

/* bench/sorted_key_insert_table_unit_test.sv */
`timescale 1ns / 1ps

module sorted_key_insert_table_unit_test;
    import skit_pkg::*;

    localparam int MAX_ENTRIES = 1024;
    localparam int MODE_COUNT  = 8;
    localparam int QUANTA_BITS = 4;

    // no accepted item on either side for this long means the block is stuck;
    // it allows for one insert at a full shift, plus receiver stalls
    localparam int WATCHDOG_LIMIT   = 20000;
    // quiet time after the last result, about one worst-case item
    localparam int END_DRAIN_CYCLES = 1100;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;   // upper half of s_axis_tdata
        logic [KEY_W-1:0]    key;      // lower half of s_axis_tdata
    } insert_request_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              present;
        logic              full;
    } slot_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;     // state_key, state_energy
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;          // slot_position, already_present, table_full

    sorted_key_insert_table_unit #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MODE_COUNT  (MODE_COUNT),
        .QUANTA_BITS (QUANTA_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // items waiting to be sent, and results owed by the block, oldest first
    insert_request_t insert_requests [$];
    slot_result_t    expected_slots [$];

    // predicted table contents, kept sorted
    logic [KEY_W-1:0]    sorted_keys [$];
    logic [ENERGY_W-1:0] sorted_energies [$];

    // keys handed to the block so far, used to aim stimulus at hits
    bit                  issued_keys [logic [KEY_W-1:0]];
    logic [KEY_W-1:0]    issued_list [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int stall_cycles = 0;
    bit in_accepted = 1'b0;

    insert_request_t next_item;
    slot_result_t    got_slot;
    slot_result_t    want_slot;

    // only the top MODE_COUNT*QUANTA_BITS bits of a key take part
    function automatic logic [KEY_W-1:0] key_mask();
        int used;
        used = MODE_COUNT * QUANTA_BITS;
        if (used >= KEY_W)
            return '1;
        return ~((KEY_W'(1) << (KEY_W - used)) - KEY_W'(1));
    endfunction

    // lower-bound search, then insert when absent and there is room
    function automatic slot_result_t lookup_and_insert(input logic [KEY_W-1:0] raw_key,
                                                       input logic [ENERGY_W-1:0] energy);
        logic [KEY_W-1:0] key;
        slot_result_t     res;
        int               lo;
        int               hi;
        int               mid;
        key = raw_key & key_mask();
        lo  = 0;
        hi  = sorted_keys.size();
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (sorted_keys[mid] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        res.slot    = SLOT_W'(lo);
        res.present = 1'b0;
        res.full    = 1'b0;
        if (lo < sorted_keys.size() && sorted_keys[lo] == key)
            res.present = 1'b1;
        else if (sorted_keys.size() >= MAX_ENTRIES)
            res.full = 1'b1;
        else
        begin
            sorted_keys.insert(lo, key);
            sorted_energies.insert(lo, energy);
        end
        return res;
    endfunction

    task automatic queue_item(input logic [KEY_W-1:0] key, input logic [ENERGY_W-1:0] energy);
        logic [KEY_W-1:0] masked;
        masked = key & key_mask();
        insert_requests.push_back({energy, key});
        if (!issued_keys.exists(masked) && issued_keys.num() < MAX_ENTRIES)
        begin
            issued_keys[masked] = 1'b1;
            issued_list.push_back(masked);
        end
    endtask

    // keys already sent or their neighbours, clustered small quanta, or noise
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        int               sel;
        sel = $urandom_range(99);
        if (issued_list.size() > 0 && sel < 30)
            k = issued_list[$urandom_range(issued_list.size() - 1)];
        else if (issued_list.size() > 0 && sel < 45)
        begin
            k = issued_list[$urandom_range(issued_list.size() - 1)];
            k = sel[0] ? k + KEY_W'(1) : k - KEY_W'(1);
        end
        else if (sel < 75)
        begin
            for (int m = 0; m < KEY_W / 4; m++)
                k[4*m +: 4] = 4'($urandom_range(3));
        end
        else
            k = $urandom();
        // all-ones held back so the directed largest key always lands at the end
        if (k == '1)
            k = k - KEY_W'(1);
        return k;
    endfunction

    // sender side: a new item goes out at the falling edge once the previous one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_accepted))
        begin
            if (insert_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_item = insert_requests.pop_front();
                s_axis_tdata  <= next_item;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver side
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // sample both handshakes at the rising edge, predict and check
    always @(posedge clk)
    begin
        in_accepted = s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (in_accepted)
                expected_slots.push_back(lookup_and_insert(s_axis_tdata[KEY_W-1:0],
                                                           s_axis_tdata[IN_W-1:KEY_W]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_slot = {m_axis_tdata[SLOT_W-1:0], m_axis_tdata[SLOT_W],
                            m_axis_tdata[SLOT_W+1]};
                if (expected_slots.size() == 0)
                begin
                    $error("result with nothing expected: tdata %h", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want_slot = expected_slots.pop_front();
                    if (got_slot.slot !== want_slot.slot)
                    begin
                        $error("slot_position: expected %0d, got %0d",
                               want_slot.slot, got_slot.slot);
                        mismatches++;
                    end
                    if (got_slot.present !== want_slot.present)
                    begin
                        $error("already_present: expected %0b, got %0b",
                               want_slot.present, got_slot.present);
                        mismatches++;
                    end
                    if (got_slot.full !== want_slot.full)
                    begin
                        $error("table_full: expected %0b, got %0b",
                               want_slot.full, got_slot.full);
                        mismatches++;
                    end
                end
            end
            if (in_accepted || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic drain();
        while (insert_requests.size() > 0 || s_axis_tvalid || expected_slots.size() > 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic queue_random(input int count);
        for (int n = 0; n < count; n++)
            queue_item(pick_key(), $urandom());
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver heavily
        send_idle_pct = 23;
        recv_idle_pct = 69;
        queue_item(32'h1234_5678, 32'h0000_0000);   // empty table, lands at slot 0
        queue_item(32'h1234_5678, 32'hFFFF_FFFF);   // same key again, no insert
        queue_item(32'h0000_0000, 32'hFFFF_FFFF);   // smallest key, goes in front
        queue_item(32'h0000_0000, 32'h0000_0000);   // hit at slot 0
        queue_item(32'h8000_0000, $urandom());      // appended at the end
        queue_item(32'h7FFF_FFFF, $urandom());      // between the last two
        queue_item(32'h1234_5677, 32'hFFFF_FFFF);   // one below an entry
        queue_item(32'h1234_5679, 32'h0000_0000);   // one above an entry
        queue_item(32'hFFFF_FFFE, $urandom());      // near the top
        queue_item(32'h1000_0000, $urandom());      // mode 0 = 1 with the lower modes zero
        queue_item(32'h0FFF_FFFF, $urandom());      // lower modes maxed, still below mode 0 = 1
        queue_item(32'h0000_0001, $urandom());      // last mode only
        queue_item(32'h7FFF_FFFF, $urandom());      // hit in the middle
        queue_item(32'hA5A5_A5A5, 32'h5A5A_5A5A);
        queue_item(32'h5A5A_5A5A, 32'hA5A5_A5A5);
        queue_random(180);
        drain();

        // roles swapped: sender idles heavily, receiver lightly
        send_idle_pct = 69;
        recv_idle_pct = 23;
        queue_random(180);
        drain();

        // full rate, with the largest key appended partway through
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(160);
        queue_item(32'hFFFF_FFFF, $urandom());      // largest key, lands after every entry
        queue_random(34);
        drain();

        repeat (END_DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_slots.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
